>>> rtl/core/pen_plane_bus_writer_macros.svh
// Assertion helpers shared by the RTL.
`ifndef PEN_PLANE_BUS_WRITER_MACROS_SVH
`define PEN_PLANE_BUS_WRITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPBW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pen_plane_bus_writer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PPBW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pen_plane_bus_writer: next-cycle check failed");

`endif

>>> rtl/core/ppbw_pkg.sv
`default_nettype none
package ppbw_pkg;

  localparam int PIXELS = 8;
  localparam int GROUP_ADDR_BITS = 13;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [15:0] ADDR_WINDOW_MASK = 16'hE000;
  localparam logic [15:0] ADDR_WINDOW      = 16'h6000;
  localparam logic [15:0] REG_PEN_BANK     = 16'h9000;
  localparam logic [15:0] REG_SCROLL_HI    = 16'h9200;
  localparam logic [15:0] REG_SCROLL_LO    = 16'h9400;
  localparam logic [15:0] REG_FLIP         = 16'h9600;
  localparam logic [15:0] REG_SOUND        = 16'h9A00;

endpackage
`default_nettype wire

>>> rtl/core/pen_plane_bus_writer.sv
// pen_plane_bus_writer: CPU write side of a pen-plane video board.
// Input channel (in_valid/in_stall) carries one transaction: a CPU bus write
// (action 0: address, data) or a display fetch (action 1: group_index).
// Output channel (out_valid/out_stall) returns exactly one result per
// transaction: the touched or fetched pixel group with group_valid, and the
// pen, bank, scroll, flip and sound latch registers after the transaction,
// with sound_irq high on the transaction that wrote the sound latch.
// The pixel store is read on the accept edge and written back
// (read-modify-write) when the transaction finishes its write-back step,
// through the store's separate read and write ports.
// A new transaction is accepted while the previous result waits in the
// output register; when out_stall holds that result, the next transaction
// waits in its write-back step and the input side stalls behind it.
// After rst, a clearing pass zeroes the store one group per cycle, from
// group 0 to the last group; in_stall stays high until it completes.
`default_nettype none
`include "pen_plane_bus_writer_macros.svh"
module pen_plane_bus_writer import ppbw_pkg::*; #(
  parameter int GROUP_COUNT = 8192,
  parameter int PEN_BITS    = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  input  wire logic [12:0] group_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      pixel_group,
  output logic             group_valid,
  output logic [2:0]       current_pen,
  output logic [3:0]       graphics_bank,
  output logic [15:0]      scroll_x,
  output logic             flip_screen,
  output logic [7:0]       sound_latch,
  output logic             sound_irq
);

  localparam int AW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int GW = PIXELS * PEN_BITS;
  localparam logic [GROUP_ADDR_BITS:0] GROUP_LIMIT = (GROUP_ADDR_BITS + 1)'(GROUP_COUNT);
  localparam logic [AW-1:0] LAST_GROUP = AW'(GROUP_COUNT - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MOD   = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [AW-1:0] clr_idx;

  logic        act_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic [12:0] gidx_q;

  logic [PEN_BITS-1:0] pen_reg;
  logic [3:0]          bank_reg;
  logic [15:0]         scroll_reg;
  logic                flip_reg;
  logic [7:0]          latch_reg;

  logic [PEN_BITS-1:0] pen_next;
  logic [3:0]          bank_next;
  logic [15:0]         scroll_next;
  logic                flip_next;
  logic [7:0]          latch_next;
  logic                irq_next;

  logic [GW-1:0] mem [GROUP_COUNT];
  logic [GW-1:0] mem_rdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [GW-1:0] mem_wdata;

  logic          in_acc;
  logic          finish;
  logic [12:0]   rd_idx;
  logic          rd_in_range;
  logic          is_fetch;
  logic          in_window;
  logic [12:0]   wr_idx;
  logic          fetch_hit;
  logic          store_hit;
  logic [GW-1:0] merged;
  logic [GW-1:0] group_result;
  logic [63:0]   group_wide;
  logic [7:0]    pen_wide;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && (state == ST_IDLE);
  assign finish   = (state == ST_MOD) && (!out_valid || !out_stall);

  assign rd_idx      = (action == ACT_FETCH) ? group_index : address[GROUP_ADDR_BITS-1:0];
  assign rd_in_range = {1'b0, rd_idx} < GROUP_LIMIT;
  assign mem_re      = in_acc && rd_in_range;
  assign mem_raddr   = rd_idx[AW-1:0];

  assign is_fetch  = (act_q == ACT_FETCH);
  assign in_window = (addr_q & ADDR_WINDOW_MASK) == ADDR_WINDOW;
  assign wr_idx    = addr_q[GROUP_ADDR_BITS-1:0];
  assign fetch_hit = is_fetch && ({1'b0, gidx_q} < GROUP_LIMIT);
  assign store_hit = !is_fetch && in_window && ({1'b0, wr_idx} < GROUP_LIMIT);

  ppbw_merge #(
    .PEN_BITS (PEN_BITS)
  ) u_merge (
    .pen       (pen_reg),
    .byte_in   (data_q),
    .group_in  (mem_rdata),
    .group_out (merged)
  );

  always_comb begin
    if (fetch_hit) begin
      group_result = mem_rdata;
    end else if (store_hit) begin
      group_result = merged;
    end else begin
      group_result = '0;
    end
  end

  assign group_wide = 64'(group_result);
  assign pen_wide   = 8'(pen_next);

  always_comb begin
    pen_next    = pen_reg;
    bank_next   = bank_reg;
    scroll_next = scroll_reg;
    flip_next   = flip_reg;
    latch_next  = latch_reg;
    irq_next    = 1'b0;
    if (!is_fetch && !in_window) begin
      priority if (addr_q == REG_PEN_BANK) begin
        pen_next  = data_q[PEN_BITS-1:0];
        bank_next = data_q[7:4];
      end else if (addr_q == REG_SCROLL_HI) begin
        scroll_next = {data_q, scroll_reg[7:0]};
      end else if (addr_q == REG_SCROLL_LO) begin
        scroll_next = {scroll_reg[15:8], data_q};
      end else if (addr_q == REG_FLIP) begin
        flip_next = data_q[0];
      end else if (addr_q == REG_SOUND) begin
        latch_next = data_q;
        irq_next   = 1'b1;
      end else begin
        // drop unmapped writes
      end
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else begin
      mem_we    = finish && store_hit;
      mem_waddr = wr_idx[AW-1:0];
      mem_wdata = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == LAST_GROUP) state_next = ST_IDLE;
      ST_IDLE:  if (in_acc) state_next = ST_MOD;
      ST_MOD:   if (finish) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      out_valid  <= 1'b0;
      pen_reg    <= '0;
      bank_reg   <= '0;
      scroll_reg <= '0;
      flip_reg   <= 1'b0;
      latch_reg  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (finish) begin
        out_valid  <= 1'b1;
        pen_reg    <= pen_next;
        bank_reg   <= bank_next;
        scroll_reg <= scroll_next;
        flip_reg   <= flip_next;
        latch_reg  <= latch_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_q  <= action;
      addr_q <= address;
      data_q <= data;
      gidx_q <= group_index;
    end
    if (finish) begin
      pixel_group   <= group_wide[23:0];
      group_valid   <= fetch_hit || store_hit;
      current_pen   <= pen_wide[2:0];
      graphics_bank <= bank_next;
      scroll_x      <= scroll_next;
      flip_screen   <= flip_next;
      sound_latch   <= latch_next;
      sound_irq     <= irq_next;
    end
  end

  `PPBW_ASSERT_NOW(a_clear_no_result, clk, rst, state == ST_CLEAR, !out_valid)
  `PPBW_ASSERT_NEXT(a_accept_to_mod, clk, rst, in_acc, state == ST_MOD)
  `PPBW_ASSERT_NOW(a_irq_no_group, clk, rst, out_valid && sound_irq, !group_valid)
  `PPBW_ASSERT_NEXT(a_result_after_mod, clk, rst, finish, out_valid && state == ST_IDLE)

endmodule
`default_nettype wire

>>> rtl/core/ppbw_merge.sv
`default_nettype none
module ppbw_merge import ppbw_pkg::*; #(
  parameter int PEN_BITS = 3
) (
  input  wire logic [PEN_BITS-1:0]        pen,
  input  wire logic [7:0]                 byte_in,
  input  wire logic [PIXELS*PEN_BITS-1:0] group_in,
  output logic      [PIXELS*PEN_BITS-1:0] group_out
);

  always_comb begin
    logic [PEN_BITS-1:0] pix;
    logic                bit_set;
    pix       = '0;
    bit_set   = 1'b0;
    group_out = '0;
    if (pen != {PEN_BITS{1'b1}}) begin
      for (int i = 0; i < PIXELS; i++) begin
        pix     = group_in[i*PEN_BITS +: PEN_BITS];
        bit_set = byte_in[PIXELS-1-i];
        if (pix == pen) begin
          pix = bit_set ? pen : '0;
        end else if (bit_set) begin
          pix = pix | pen;
        end
        group_out[i*PEN_BITS +: PEN_BITS] = pix;
      end
    end
  end

endmodule
`default_nettype wire
